[design/compensated_float_sum_unit_macros.svh]
// ----------------------------------------------------------------------------
// Compensated float sum unit assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef COMPENSATED_FLOAT_SUM_UNIT_MACROS_SVH
`define COMPENSATED_FLOAT_SUM_UNIT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define CFS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("cfs assertion failed");

// Property checked at every rising clock edge, reset included.
`define CFS_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("cfs assertion failed");

`endif

[design/cfs_pkg.sv]
// ----------------------------------------------------------------------------
// Compensated float sum package
// Types and constants shared by the front end, the back end and the checker.
// ----------------------------------------------------------------------------
package cfs_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_NONFINITE = 2'd2;

	localparam logic [63:0] FP_POS_ZERO = 64'h0000_0000_0000_0000;
	localparam logic [63:0] FP_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
	localparam logic [63:0] FP_QUIET_BIT = 64'h0008_0000_0000_0000;
	localparam logic [10:0] FP_EXP_ONES = 11'h7FF;

	typedef struct packed {
		logic [63:0] value;
		logic        last;
		logic        bad;
	} queue_item_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] a;
		logic [63:0] b;
		logic        sub;
	} fadd_req_t;

endpackage

[design/cfs_fadd.sv]
// ----------------------------------------------------------------------------
// Double precision adder
// Four stage pipeline: unpack and swap, align and add, normalize, round.
// ----------------------------------------------------------------------------
module cfs_fadd (
	input  logic              clk,
	input  logic              arst_n,
	input  cfs_pkg::fadd_req_t req,
	output logic              res_valid,
	output logic [63:0]       res
);

	function automatic logic [5:0] lzc56(input logic [55:0] x);
		logic [5:0] n;
		n = 6'd56;
		for (int i = 0; i < 56; i++) begin
			if (x[i]) begin
				n = 6'(55 - i);
			end
		end
		return n;
	endfunction

	logic [63:0] bn;
	logic        a_nan, a_inf, b_nan, b_inf, swap;
	logic [63:0] big, sml, spec_res;
	logic [10:0] eb, es;

	logic        v_s1, spec_s1, sign_s1, sub_s1;
	logic [63:0] spec_res_s1;
	logic [10:0] exp_s1, diff_s1;
	logic [52:0] mb_s1, ms_s1;

	logic        v_s2, spec_s2, sign_s2, sub_s2;
	logic [63:0] spec_res_s2;
	logic [10:0] exp_s2;
	logic [56:0] sum_s2;

	logic        v_s3, spec_s3, sign_s3, zero_s3;
	logic [63:0] spec_res_s3;
	logic [11:0] exp_s3;
	logic [55:0] m_s3;

	logic        v_s4;
	logic [63:0] res_s4;

	logic [5:0]  dd;
	logic [55:0] ext, lost, al;
	logic [56:0] big57, sum;

	logic [5:0]  lz, sh;
	logic [10:0] lim;
	logic [55:0] m_n;
	logic [11:0] e_n;

	logic        up;
	logic [10:0] ef;
	logic [62:0] packed_v;
	logic [63:0] fin;

	always_comb begin
		bn = {req.b[63] ^ req.sub, req.b[62:0]};
		a_nan = (req.a[62:52] == cfs_pkg::FP_EXP_ONES) && (|req.a[51:0]);
		a_inf = (req.a[62:52] == cfs_pkg::FP_EXP_ONES) && !(|req.a[51:0]);
		b_nan = (bn[62:52] == cfs_pkg::FP_EXP_ONES) && (|bn[51:0]);
		b_inf = (bn[62:52] == cfs_pkg::FP_EXP_ONES) && !(|bn[51:0]);
		swap = bn[62:0] > req.a[62:0];
		big = swap ? bn : req.a;
		sml = swap ? req.a : bn;
		eb = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
		es = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
		if (a_nan) begin
			spec_res = req.a | cfs_pkg::FP_QUIET_BIT;
		end else if (b_nan) begin
			spec_res = req.b | cfs_pkg::FP_QUIET_BIT;
		end else if (a_inf && b_inf && (req.a[63] != bn[63])) begin
			spec_res = cfs_pkg::FP_DEFAULT_NAN;
		end else if (a_inf) begin
			spec_res = req.a;
		end else begin
			spec_res = bn;
		end
	end

	always_comb begin
		dd = (|diff_s1[10:6]) ? 6'd63 : diff_s1[5:0];
		ext = {ms_s1, 3'b000};
		lost = ext & ~({56{1'b1}} << dd);
		al = (ext >> dd) | {55'd0, |lost};
		big57 = {1'b0, mb_s1, 3'b000};
		sum = sub_s1 ? (big57 - {1'b0, al}) : (big57 + {1'b0, al});
	end

	always_comb begin
		lz = lzc56(sum_s2[55:0]);
		lim = exp_s2 - 11'd1;
		sh = ({5'd0, lz} > lim) ? lim[5:0] : lz;
		if (sum_s2[56]) begin
			m_n = {sum_s2[56:2], sum_s2[1] | sum_s2[0]};
			e_n = {1'b0, exp_s2} + 12'd1;
		end else begin
			m_n = sum_s2[55:0] << sh;
			e_n = {1'b0, exp_s2} - {6'd0, sh};
		end
	end

	always_comb begin
		up = m_s3[2] & (m_s3[1] | m_s3[0] | m_s3[3]);
		ef = m_s3[55] ? exp_s3[10:0] : 11'd0;
		packed_v = {ef, m_s3[54:3]} + {62'd0, up};
		if (spec_s3) begin
			fin = spec_res_s3;
		end else if (zero_s3) begin
			fin = {sign_s3, 63'd0};
		end else if (exp_s3 >= {1'b0, cfs_pkg::FP_EXP_ONES}) begin
			fin = {sign_s3, cfs_pkg::FP_EXP_ONES, 52'd0};
		end else begin
			fin = {sign_s3, packed_v};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		spec_s1 <= a_nan | a_inf | b_nan | b_inf;
		spec_res_s1 <= spec_res;
		sign_s1 <= big[63];
		sub_s1 <= big[63] ^ sml[63];
		exp_s1 <= eb;
		diff_s1 <= eb - es;
		mb_s1 <= {big[62:52] != 11'd0, big[51:0]};
		ms_s1 <= {sml[62:52] != 11'd0, sml[51:0]};

		spec_s2 <= spec_s1;
		spec_res_s2 <= spec_res_s1;
		sign_s2 <= sign_s1;
		sub_s2 <= sub_s1;
		exp_s2 <= exp_s1;
		sum_s2 <= sum;

		spec_s3 <= spec_s2;
		spec_res_s3 <= spec_res_s2;
		zero_s3 <= (sum_s2 == 57'd0);
		sign_s3 <= (sum_s2 == 57'd0 && sub_s2) ? 1'b0 : sign_s2;
		exp_s3 <= e_n;
		m_s3 <= m_n;

		res_s4 <= fin;
	end

	assign res_valid = v_s4;
	assign res = res_s4;

endmodule

[design/cfs_front.sv]
// ----------------------------------------------------------------------------
// Compensated float sum front end
// Accepts values, marks invalid ones and queues them for the back end.
// ----------------------------------------------------------------------------
module cfs_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 value_valid,
	output logic                 value_stall,
	input  logic [63:0]          value_bits,
	input  logic                 last_item,
	output logic                 q_valid,
	output cfs_pkg::queue_item_t q_item,
	input  logic                 q_pop
);

	cfs_pkg::queue_item_t mem_q [cfs_pkg::QUEUE_DEPTH];
	logic [cfs_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [cfs_pkg::QCNT_W-1:0] cnt_q;
	logic push, pop;
	cfs_pkg::queue_item_t in_item;

	always_comb begin
		in_item.value = value_bits;
		in_item.last = last_item;
		in_item.bad = (value_bits[62:52] == cfs_pkg::FP_EXP_ONES) ||
			(value_bits[63] && (|value_bits[62:0]));
	end

	assign value_stall = (cnt_q == cfs_pkg::QCNT_W'(cfs_pkg::QUEUE_DEPTH));
	assign push = value_valid && !value_stall;
	assign q_valid = (cnt_q != '0);
	assign pop = q_pop && q_valid;
	assign q_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[design/cfs_back.sv]
// ----------------------------------------------------------------------------
// Compensated float sum back end
// Runs the compensated add steps on the shared adder and holds the result.
// ----------------------------------------------------------------------------
module cfs_back #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  cfs_pkg::queue_item_t q_item,
	output logic                 q_pop,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [63:0]          total_bits,
	output logic [31:0]          run_length,
	output logic [1:0]           status
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_CAND, ST_DIFF, ST_CORR, ST_ERR, ST_TOTAL, ST_EMIT
	} state_t;

	state_t state_q;
	logic busy_q, last_q, bad_q, ge_q;
	logic [63:0] sum_q, err_q, cand_q, tmp_q, val_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [31:0] cnt_out;
	logic out_valid_q;
	logic [63:0] out_total_q;
	logic [31:0] out_count_q;
	logic [1:0] out_status_q;
	cfs_pkg::fadd_req_t req;
	logic res_valid;
	logic [63:0] res;
	logic compute;

	generate
		if (COUNT_WIDTH > 32) begin : g_wide
			assign cnt_out = (|cnt_q[COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF : cnt_q[31:0];
		end else begin : g_narrow
			assign cnt_out = 32'(cnt_q);
		end
	endgenerate

	always_comb begin
		compute = (state_q == ST_CAND) || (state_q == ST_DIFF) || (state_q == ST_CORR) ||
			(state_q == ST_ERR) || (state_q == ST_TOTAL);
		req.valid = compute && !busy_q;
		req.a = sum_q;
		req.b = val_q;
		req.sub = 1'b0;
		unique case (state_q)
			ST_DIFF: begin
				req.a = ge_q ? sum_q : val_q;
				req.b = cand_q;
				req.sub = 1'b1;
			end
			ST_CORR: begin
				req.a = tmp_q;
				req.b = ge_q ? val_q : sum_q;
			end
			ST_ERR: begin
				req.a = err_q;
				req.b = tmp_q;
			end
			ST_TOTAL: begin
				req.a = sum_q;
				req.b = err_q;
			end
			default: begin
				req.a = sum_q;
				req.b = val_q;
			end
		endcase
	end

	assign q_pop = (state_q == ST_IDLE) && q_valid;

	cfs_fadd u_fadd (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q <= 1'b0;
			last_q <= 1'b0;
			bad_q <= 1'b0;
			ge_q <= 1'b0;
			sum_q <= cfs_pkg::FP_POS_ZERO;
			err_q <= cfs_pkg::FP_POS_ZERO;
			cand_q <= cfs_pkg::FP_POS_ZERO;
			tmp_q <= cfs_pkg::FP_POS_ZERO;
			val_q <= cfs_pkg::FP_POS_ZERO;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			out_total_q <= '0;
			out_count_q <= '0;
			out_status_q <= cfs_pkg::STATUS_OK;
		end else begin
			if (out_valid_q && !result_stall && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			if (req.valid) begin
				busy_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						val_q <= q_item.value;
						last_q <= q_item.last;
						ge_q <= !((sum_q[62:52] == cfs_pkg::FP_EXP_ONES) && (|sum_q[51:0])) &&
							(sum_q[62:0] >= q_item.value[62:0]);
						if (cnt_q != '1) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (q_item.bad) begin
							bad_q <= 1'b1;
							state_q <= q_item.last ? ST_EMIT : ST_IDLE;
						end else begin
							state_q <= ST_CAND;
						end
					end
				end
				ST_CAND: begin
					if (res_valid) begin
						busy_q <= 1'b0;
						cand_q <= res;
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					if (res_valid) begin
						busy_q <= 1'b0;
						tmp_q <= res;
						state_q <= ST_CORR;
					end
				end
				ST_CORR: begin
					if (res_valid) begin
						busy_q <= 1'b0;
						tmp_q <= res;
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					if (res_valid) begin
						busy_q <= 1'b0;
						err_q <= res;
						sum_q <= cand_q;
						state_q <= last_q ? ST_TOTAL : ST_IDLE;
					end
				end
				ST_TOTAL: begin
					if (res_valid) begin
						busy_q <= 1'b0;
						tmp_q <= res;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || !result_stall) begin
						out_valid_q <= 1'b1;
						out_count_q <= cnt_out;
						if (bad_q) begin
							out_total_q <= '0;
							out_status_q <= cfs_pkg::STATUS_INVALID;
						end else begin
							out_total_q <= tmp_q;
							out_status_q <= (tmp_q[62:52] == cfs_pkg::FP_EXP_ONES) ?
								cfs_pkg::STATUS_NONFINITE : cfs_pkg::STATUS_OK;
						end
						sum_q <= cfs_pkg::FP_POS_ZERO;
						err_q <= cfs_pkg::FP_POS_ZERO;
						cnt_q <= '0;
						bad_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign total_bits = out_total_q;
	assign run_length = out_count_q;
	assign status = out_status_q;

endmodule

[design/compensated_float_sum_unit.sv]
// A run's last valid value gives its result after the queue, its four dependent
// adds and a final total add on the four stage adder, and the output register.
// Each valid value holds the back end until its adds finish; an invalid one uses no add.
// A four entry queue decouples input transfers from the back end.
// Reset clears the running sum, correction, count and error flag at once.
// ----------------------------------------------------------------------------
// Compensated float sum unit
// Neumaier compensated summation of a run of doubles with a final report.
// ----------------------------------------------------------------------------
module compensated_float_sum_unit #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        value_valid,
	output logic        value_stall,
	input  logic [63:0] value_bits,
	input  logic        last_item,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [63:0] total_bits,
	output logic [31:0] run_length,
	output logic [1:0]  status
);

	logic                 q_valid;
	logic                 q_pop;
	cfs_pkg::queue_item_t q_item;

	cfs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.value_bits  (value_bits),
		.last_item   (last_item),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	cfs_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.total_bits   (total_bits),
		.run_length   (run_length),
		.status       (status)
	);

endmodule

[design/cfs_checker.sv]
// ----------------------------------------------------------------------------
// Compensated float sum checker
// Port level properties of the result channel.
// ----------------------------------------------------------------------------
`include "compensated_float_sum_unit_macros.svh"

module cfs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic [63:0] total_bits,
	input logic [31:0] run_length,
	input logic [1:0]  status
);

	`CFS_ASSERT(a_invalid_zero, clk, arst_n, (result_valid && status == cfs_pkg::STATUS_INVALID) |-> (total_bits == 64'd0))
	`CFS_ASSERT(a_nonfinite_exp, clk, arst_n, (result_valid && status == cfs_pkg::STATUS_NONFINITE) |-> (total_bits[62:52] == cfs_pkg::FP_EXP_ONES))
	`CFS_ASSERT(a_count_nonzero, clk, arst_n, result_valid |-> (run_length != 32'd0))
	`CFS_ASSERT(a_hold_stalled, clk, arst_n, (result_valid && result_stall) |=> (result_valid && $stable(total_bits) && $stable(status)))

endmodule

bind compensated_float_sum_unit cfs_checker u_cfs_checker (.*);
